// File: hw/rtl/proximity_alarm_mode_controller_unit_defines.svh
// assertion helpers for the controller rtl
`ifndef PROXIMITY_ALARM_MODE_CONTROLLER_UNIT_DEFINES_SVH
`define PROXIMITY_ALARM_MODE_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define PAMC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAMC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pamc_pkg.sv
`default_nettype none

package pamc_pkg;

  localparam int MM_W       = 16;
  localparam int CM_W       = 13;
  localparam int LIM_W      = 10;
  localparam int BEAT_W     = 10;
  localparam int SVC_W      = 8;
  localparam int GUARD_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_FULL   = 2'd0;
  localparam mode_t MODE_SCREEN = 2'd1;
  localparam mode_t MODE_BUZZER = 2'd2;
  localparam mode_t MODE_LED    = 2'd3;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_REMOTE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERVICE_INTERVAL,
    CFG_REMOTE_GUARD,
    CFG_FAR_LIMIT,
    CFG_SOLID_LIMIT
  } cfg_idx_t;

  // register defaults
  localparam logic [SVC_W-1:0]   SVC_INTERVAL_RST = 8'd10;
  localparam logic [GUARD_W-1:0] GUARD_MS_RST     = 16'd1000;
  localparam logic [LIM_W-1:0]   FAR_LIMIT_RST    = 10'd55;
  localparam logic [LIM_W-1:0]   SOLID_LIMIT_RST  = 10'd4;

  // band edges in cm, each band includes its upper bound
  localparam logic [CM_W-1:0] EDGE_40 = 13'd40;
  localparam logic [CM_W-1:0] EDGE_30 = 13'd30;
  localparam logic [CM_W-1:0] EDGE_20 = 13'd20;
  localparam logic [CM_W-1:0] EDGE_12 = 13'd12;
  localparam logic [CM_W-1:0] EDGE_8  = 13'd8;

  // beep half periods in ticks
  localparam logic [BEAT_W-1:0] HALF_600 = 10'd600;
  localparam logic [BEAT_W-1:0] HALF_500 = 10'd500;
  localparam logic [BEAT_W-1:0] HALF_400 = 10'd400;
  localparam logic [BEAT_W-1:0] HALF_250 = 10'd250;
  localparam logic [BEAT_W-1:0] HALF_150 = 10'd150;
  localparam logic [BEAT_W-1:0] HALF_52  = 10'd52;

  // x / 10 == (x * 0xcccd) >> 19, exact over 16 bits
  localparam logic [MM_W-1:0] DIV10_RECIP = 16'hCCCD;
  localparam int              DIV10_SHIFT = 19;

  typedef struct packed {
    logic            command;
    logic            button_level;
    logic [CM_W-1:0] distance_cm;
  } item_t;

  typedef struct packed {
    logic              off;
    logic              solid;
    logic [BEAT_W-1:0] half;
  } band_t;

  function automatic logic [CM_W-1:0] mm_to_cm(input logic [MM_W-1:0] mm);
    logic [2*MM_W-1:0] prod;
    prod = (2*MM_W)'(mm) * (2*MM_W)'(DIV10_RECIP);
    return prod[DIV10_SHIFT +: CM_W];
  endfunction

  function automatic band_t band_of(input logic [CM_W-1:0]  d,
                                    input logic [LIM_W-1:0] far_lim,
                                    input logic [LIM_W-1:0] solid_lim);
    band_t b;
    b.off   = 1'b0;
    b.solid = 1'b0;
    b.half  = '0;
    if (d > CM_W'(far_lim)) begin
      b.off = 1'b1;
    end else if (d <= CM_W'(solid_lim)) begin
      b.solid = 1'b1;
    end else if (d > EDGE_40) begin
      b.half = HALF_600;
    end else if (d > EDGE_30) begin
      b.half = HALF_500;
    end else if (d > EDGE_20) begin
      b.half = HALF_400;
    end else if (d > EDGE_12) begin
      b.half = HALF_250;
    end else if (d > EDGE_8) begin
      b.half = HALF_150;
    end else begin
      b.half = HALF_52;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pamc_in_if.sv
`default_nettype none

interface pamc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [pamc_pkg::MM_W-1:0] distance_mm;
  logic                      button_level;

  modport source(output valid, output command, output distance_mm,
                 output button_level, input ready);
  modport sink(input valid, input command, input distance_mm,
               input button_level, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pamc_out_if.sv
`default_nettype none

interface pamc_out_if;
  logic                      valid;
  logic                      ready;
  logic                      led_on;
  logic                      buzzer_on;
  pamc_pkg::mode_t           current_mode_code;
  logic [pamc_pkg::CM_W-1:0] distance_cm_out;
  logic                      mode_changed;

  modport source(output valid, output led_on, output buzzer_on,
                 output current_mode_code, output distance_cm_out,
                 output mode_changed, input ready);
  modport sink(input valid, input led_on, input buzzer_on,
               input current_mode_code, input distance_cm_out,
               input mode_changed, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pamc_cfg_if.sv
`default_nettype none

interface pamc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pamc_pkg::CFG_IDX_W-1:0]  index;
  logic [pamc_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pamc_in_stage.sv
`default_nettype none

module pamc_in_stage (
  input  logic              clk,
  input  logic              rst,
  pamc_in_if.sink           item,
  input  logic              advance,
  output logic              stage_valid,
  output pamc_pkg::item_t   stage_item
);

  logic accept;

  assign item.ready = !stage_valid || advance;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // cm conversion is done on the way in, off the state update path
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item.command      <= item.command;
      stage_item.button_level <= item.button_level;
      stage_item.distance_cm  <= pamc_pkg::mm_to_cm(item.distance_mm);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pamc_core.sv
`default_nettype none
`include "proximity_alarm_mode_controller_unit_defines.svh"

module pamc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            stage_valid,
  input  pamc_pkg::item_t stage_item,
  output logic            advance,
  pamc_cfg_if.sink        cfg,
  pamc_out_if.source      result
);

  // configuration
  logic [pamc_pkg::SVC_W-1:0]   svc_interval;
  logic [pamc_pkg::GUARD_W-1:0] guard_ms;
  logic [pamc_pkg::LIM_W-1:0]   far_limit;
  logic [pamc_pkg::LIM_W-1:0]   solid_limit;

  // controller state
  pamc_pkg::mode_t              mode_reg;
  logic [pamc_pkg::CM_W-1:0]    distance_cm_reg;
  logic [pamc_pkg::SVC_W-1:0]   service_count;
  logic [pamc_pkg::BEAT_W-1:0]  beat_count;
  logic [pamc_pkg::GUARD_W-1:0] guard_count;
  logic                         remote_allowed;
  logic                         button_prev;
  logic                         led_reg;
  logic                         buzzer_reg;

  pamc_pkg::mode_t              mode_reg_next;
  logic [pamc_pkg::CM_W-1:0]    distance_cm_reg_next;
  logic [pamc_pkg::SVC_W-1:0]   service_count_next;
  logic [pamc_pkg::BEAT_W-1:0]  beat_count_next;
  logic [pamc_pkg::GUARD_W-1:0] guard_count_next;
  logic                         remote_allowed_next;
  logic                         button_prev_next;
  logic                         led_reg_next;
  logic                         buzzer_reg_next;
  logic                         changed_next;

  assign advance   = stage_valid && (!result.valid || result.ready);
  assign cfg.ready = 1'b1;

  always_comb begin
    logic [pamc_pkg::SVC_W-1:0]   svc_dec;
    logic [pamc_pkg::BEAT_W-1:0]  beat_dec;
    logic [pamc_pkg::GUARD_W-1:0] guard_load;
    logic [pamc_pkg::GUARD_W-1:0] guard_cur;
    logic                         use_led;
    logic                         use_buz;
    pamc_pkg::band_t              band;

    mode_reg_next        = mode_reg;
    distance_cm_reg_next = distance_cm_reg;
    service_count_next   = service_count;
    beat_count_next      = beat_count;
    guard_count_next     = guard_count;
    remote_allowed_next  = remote_allowed;
    button_prev_next     = button_prev;
    led_reg_next         = led_reg;
    buzzer_reg_next      = buzzer_reg;
    changed_next         = 1'b0;

    svc_dec    = (service_count != '0) ? service_count - 1'b1 : service_count;
    beat_dec   = (beat_count != '0) ? beat_count - 1'b1 : beat_count;
    guard_load = (guard_ms == '0) ? pamc_pkg::GUARD_W'(1) : guard_ms;
    guard_cur  = (guard_count == '0) ? guard_load : guard_count;
    use_led    = (mode_reg == pamc_pkg::MODE_FULL) || (mode_reg == pamc_pkg::MODE_LED);
    use_buz    = (mode_reg == pamc_pkg::MODE_FULL) || (mode_reg == pamc_pkg::MODE_BUZZER);
    band       = pamc_pkg::band_of(stage_item.distance_cm, far_limit, solid_limit);

    if (advance) begin
      if (stage_item.command == pamc_pkg::CMD_REMOTE) begin
        if (remote_allowed) begin
          mode_reg_next       = mode_reg + 1'b1;
          remote_allowed_next = 1'b0;
          changed_next        = 1'b1;
        end
      end else begin
        service_count_next = svc_dec;
        beat_count_next    = beat_dec;
        guard_count_next   = guard_cur - 1'b1;
        if (guard_count == '0) begin
          remote_allowed_next = 1'b1;
        end
        if (svc_dec == '0) begin
          service_count_next   = svc_interval;
          distance_cm_reg_next = stage_item.distance_cm;
          // drive from the fresh sample, mode before any button step
          if (mode_reg == pamc_pkg::MODE_SCREEN) begin
            led_reg_next    = 1'b0;
            buzzer_reg_next = 1'b0;
          end else if (beat_dec == '0) begin
            if (band.off) begin
              led_reg_next    = 1'b0;
              buzzer_reg_next = 1'b0;
            end else if (band.solid) begin
              led_reg_next    = use_led;
              buzzer_reg_next = use_buz;
            end else begin
              beat_count_next = band.half;
              led_reg_next    = use_led && !led_reg;
              buzzer_reg_next = use_buz && !buzzer_reg;
            end
          end
          if (stage_item.button_level && !button_prev) begin
            mode_reg_next = mode_reg + 1'b1;
            changed_next  = 1'b1;
          end
          button_prev_next = stage_item.button_level;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      svc_interval    <= pamc_pkg::SVC_INTERVAL_RST;
      guard_ms        <= pamc_pkg::GUARD_MS_RST;
      far_limit       <= pamc_pkg::FAR_LIMIT_RST;
      solid_limit     <= pamc_pkg::SOLID_LIMIT_RST;
    end else if (cfg.valid) begin
      case (pamc_pkg::cfg_idx_t'(cfg.index))
        pamc_pkg::CFG_SERVICE_INTERVAL: svc_interval <= cfg.data[pamc_pkg::SVC_W-1:0];
        pamc_pkg::CFG_REMOTE_GUARD:     guard_ms     <= cfg.data[pamc_pkg::GUARD_W-1:0];
        pamc_pkg::CFG_FAR_LIMIT:        far_limit    <= cfg.data[pamc_pkg::LIM_W-1:0];
        pamc_pkg::CFG_SOLID_LIMIT:      solid_limit  <= cfg.data[pamc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= pamc_pkg::MODE_FULL;
      distance_cm_reg <= '0;
      service_count   <= '0;
      beat_count      <= '0;
      guard_count     <= '0;
      remote_allowed  <= 1'b0;
      button_prev     <= 1'b0;
      led_reg         <= 1'b0;
      buzzer_reg      <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      mode_reg        <= mode_reg_next;
      distance_cm_reg <= distance_cm_reg_next;
      service_count   <= service_count_next;
      beat_count      <= beat_count_next;
      guard_count     <= guard_count_next;
      remote_allowed  <= remote_allowed_next;
      button_prev     <= button_prev_next;
      led_reg         <= led_reg_next;
      buzzer_reg      <= buzzer_reg_next;
      if (advance) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.led_on            <= led_reg_next;
      result.buzzer_on         <= buzzer_reg_next;
      result.current_mode_code <= mode_reg_next;
      result.distance_cm_out   <= distance_cm_reg_next;
      result.mode_changed      <= changed_next;
    end
  end

  `PAMC_ASSERT_IMP(a_beat_bound, clk, rst, 1'b1, beat_count <= pamc_pkg::HALF_600, "beat count past longest half period")
  `PAMC_ASSERT_NXT(a_mode_hold, clk, rst, !advance, $stable(mode_reg), "mode moved without a transfer")
  `PAMC_ASSERT_NXT(a_remote_clear, clk, rst, advance && stage_item.command == pamc_pkg::CMD_REMOTE, !remote_allowed, "remote window still open after press")
  `PAMC_ASSERT_NXT(a_guard_arm, clk, rst, advance && stage_item.command == pamc_pkg::CMD_TICK && guard_count == '0, remote_allowed, "guard expiry did not open remote window")
  `PAMC_ASSERT_NXT(a_changed_flag, clk, rst, advance, result.mode_changed == (mode_reg != $past(mode_reg)), "mode_changed disagrees with mode")

endmodule

`default_nettype wire

// File: hw/rtl/proximity_alarm_mode_controller_unit.sv
// channel | role   | payload
// --------+--------+---------------------------------------------------------
// item    | sink   | command, distance_mm, button_level
// result  | source | led_on, buzzer_on, current_mode_code, distance_cm_out,
//         |        | mode_changed
// cfg     | sink   | index, data (register write, always ready)
//
// one item per cycle sustained while the result is taken; each item passes
// the input register and then the result register
// mm to cm scaling sits in the input register stage, the mode/beep update
// sits between the input register and the result register
// reset (rst, synchronous) clears control state and loads register defaults
// a stalled result holds; one more item waits in the input register, then
// item.ready drops until the result is taken
`default_nettype none

module proximity_alarm_mode_controller_unit (
  input logic        clk,
  input logic        rst,
  pamc_in_if.sink    item,
  pamc_out_if.source result,
  pamc_cfg_if.sink   cfg
);

  // input register to update stage
  logic            stage_valid;
  pamc_pkg::item_t stage_item;
  // update stage pulls the staged item
  logic            advance;

  // input register: captures the item and converts mm to cm
  pamc_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // state update, configuration registers and result register
  pamc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .advance     (advance),
    .cfg         (cfg),
    .result      (result)
  );

endmodule

`default_nettype wire

// File: dv/pamc_checker.sv
`timescale 1ns / 100ps

module pamc_checker (
  input  logic        clk,
  input  logic        rst,
  pamc_in_if          item,
  pamc_out_if         result,
  pamc_cfg_if         cfg,
  output int unsigned errors,
  output int unsigned pending
);
  import pamc_pkg::*;

  typedef struct packed {
    logic            led;
    logic            buzzer;
    mode_t           mode;
    logic [CM_W-1:0] dist_cm;
    logic            changed;
  } alarm_out_t;

  typedef struct packed {
    logic              off;
    logic              solid;
    logic [BEAT_W-1:0] half;
  } beep_plan_t;

  alarm_out_t alarm_q[$];

  // register copies
  logic [SVC_W-1:0]   svc_ivl;
  logic [GUARD_W-1:0] guard_ms;
  logic [LIM_W-1:0]   far_lim;
  logic [LIM_W-1:0]   solid_lim;

  // alarm state
  mode_t              mode;
  logic [CM_W-1:0]    dist_cm;
  logic [SVC_W-1:0]   svc_cnt;
  logic [BEAT_W-1:0]  beat_cnt;
  logic [GUARD_W-1:0] guard_cnt;
  logic               remote_ok;
  logic               btn_prev;
  logic               led;
  logic               buzzer;

  function automatic beep_plan_t plan_beep(input logic [CM_W-1:0] d);
    beep_plan_t p;
    p = '0;
    if (d > CM_W'(far_lim)) begin
      p.off = 1'b1;
    end else if (d <= CM_W'(solid_lim)) begin
      p.solid = 1'b1;
    end else if (d > 13'd40) begin
      p.half = 10'd600;
    end else if (d > 13'd30) begin
      p.half = 10'd500;
    end else if (d > 13'd20) begin
      p.half = 10'd400;
    end else if (d > 13'd12) begin
      p.half = 10'd250;
    end else if (d > 13'd8) begin
      p.half = 10'd150;
    end else begin
      p.half = 10'd52;
    end
    return p;
  endfunction

  task automatic refresh_outputs();
    beep_plan_t p;
    logic use_led;
    logic use_buz;
    use_led = (mode == MODE_FULL) || (mode == MODE_LED);
    use_buz = (mode == MODE_FULL) || (mode == MODE_BUZZER);
    if (mode == MODE_SCREEN) begin
      led    = 1'b0;
      buzzer = 1'b0;
    end else if (beat_cnt == '0) begin
      p = plan_beep(dist_cm);
      if (p.off) begin
        led    = 1'b0;
        buzzer = 1'b0;
      end else if (p.solid) begin
        led    = use_led;
        buzzer = use_buz;
      end else begin
        beat_cnt = p.half;
        led      = use_led ? !led : 1'b0;
        buzzer   = use_buz ? !buzzer : 1'b0;
      end
    end
  endtask

  task automatic step_alarm(input logic cmd, input logic [MM_W-1:0] mm, input logic btn);
    alarm_out_t r;
    logic changed;
    changed = 1'b0;
    if (cmd == CMD_REMOTE) begin
      if (remote_ok) begin
        mode      = mode_t'(mode + 2'd1);
        remote_ok = 1'b0;
        changed   = 1'b1;
      end
    end else begin
      if (svc_cnt != '0) svc_cnt = svc_cnt - 1'b1;
      if (beat_cnt != '0) beat_cnt = beat_cnt - 1'b1;
      if (guard_cnt == '0) begin
        guard_cnt = (guard_ms == '0) ? GUARD_W'(1) : guard_ms;
        remote_ok = 1'b1;
      end
      guard_cnt = guard_cnt - 1'b1;
      if (svc_cnt == '0) begin
        svc_cnt = svc_ivl;
        dist_cm = CM_W'(mm / 16'd10);
        refresh_outputs();
        if (btn && !btn_prev) begin
          mode    = mode_t'(mode + 2'd1);
          changed = 1'b1;
        end
        btn_prev = btn;
      end
    end
    r.led     = led;
    r.buzzer  = buzzer;
    r.mode    = mode;
    r.dist_cm = dist_cm;
    r.changed = changed;
    alarm_q.push_back(r);
  endtask

  function automatic int unsigned flag_field(input string name, input int unsigned want,
                                             input int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    alarm_out_t want;
    if (rst) begin
      svc_ivl   = SVC_INTERVAL_RST;
      guard_ms  = GUARD_MS_RST;
      far_lim   = FAR_LIMIT_RST;
      solid_lim = SOLID_LIMIT_RST;
      mode      = MODE_FULL;
      dist_cm   = '0;
      svc_cnt   = '0;
      beat_cnt  = '0;
      guard_cnt = '0;
      remote_ok = 1'b0;
      btn_prev  = 1'b0;
      led       = 1'b0;
      buzzer    = 1'b0;
      errors    = 0;
      alarm_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CFG_SERVICE_INTERVAL: svc_ivl   = cfg.data[SVC_W-1:0];
          CFG_REMOTE_GUARD:     guard_ms  = cfg.data[GUARD_W-1:0];
          CFG_FAR_LIMIT:        far_lim   = cfg.data[LIM_W-1:0];
          CFG_SOLID_LIMIT:      solid_lim = cfg.data[LIM_W-1:0];
          default: ;
        endcase
      end
      // a result leaves only after its item has passed both registers, so compare before adding
      if (result.valid && result.ready) begin
        if (alarm_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual led %0d buzzer %0d",
                   $time, result.led_on, result.buzzer_on);
          $display("%0t: actual mode %0d cm %0d chg %0d", $time,
                   result.current_mode_code, result.distance_cm_out, result.mode_changed);
          errors++;
        end else begin
          want = alarm_q.pop_front();
          errors += flag_field("led_on", want.led, result.led_on);
          errors += flag_field("buzzer_on", want.buzzer, result.buzzer_on);
          errors += flag_field("current_mode_code", want.mode, result.current_mode_code);
          errors += flag_field("distance_cm_out", want.dist_cm, result.distance_cm_out);
          errors += flag_field("mode_changed", want.changed, result.mode_changed);
        end
      end
      if (item.valid && item.ready) step_alarm(item.command, item.distance_mm, item.button_level);
    end
    pending <= alarm_q.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pamc_pkg::*;

  // generous bound: every item may see a full sender gap and a full result stall
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycle_cnt;

  // calm stretches: no idling on that side while set
  bit src_calm;
  bit snk_calm;

  // limits currently programmed, used to aim distances at the band edges
  logic [LIM_W-1:0] far_now   = FAR_LIMIT_RST;
  logic [LIM_W-1:0] solid_now = SOLID_LIMIT_RST;

  pamc_in_if  item_ch();
  pamc_out_if result_ch();
  pamc_cfg_if cfg_ch();

  proximity_alarm_mode_controller_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  pamc_checker alarm_chk (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall before each transfer, ready held high when no stall
  initial begin : result_side
    int unsigned stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
      stall = snk_calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // one item transfer, preceded by a random gap; valid stays high on return
  task automatic send_item(input logic cmd, input logic [MM_W-1:0] mm, input logic btn);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.command      <= cmd;
    item_ch.distance_mm  <= mm;
    item_ch.button_level <= btn;
    item_ch.valid        <= 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // pipeline is two deep, a few spare cycles cover it
    repeat (4) @(posedge clk);
  endtask

  // register write; valid kept high across back-to-back writes
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] svc, input logic [CFG_DATA_W-1:0] guard,
                              input logic [CFG_DATA_W-1:0] far, input logic [CFG_DATA_W-1:0] solid);
    write_reg(CFG_SERVICE_INTERVAL, svc);
    write_reg(CFG_REMOTE_GUARD, guard);
    write_reg(CFG_FAR_LIMIT, far);
    write_reg(CFG_SOLID_LIMIT, solid);
    cfg_ch.valid <= 1'b0;
    far_now   = far[LIM_W-1:0];
    solid_now = solid[LIM_W-1:0];
  endtask

  // runs of ticks at one distance so beats can play out, mixed with remote
  // presses, button flips and some full-range distances
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    int unsigned cm;
    logic        btn;
    logic        wild;
    logic [MM_W-1:0] mm;
    sent = 0;
    btn  = 1'($urandom);
    while (sent < n_items) begin
      wild = ($urandom_range(0, 19) >= 17);
      case ($urandom_range(0, 15))
        0:       cm = far_now;
        1:       cm = far_now + 1;
        2:       cm = solid_now;
        3:       cm = solid_now + 1;
        4:       cm = 41;
        5:       cm = 40;
        6:       cm = 31;
        7:       cm = 30;
        8:       cm = 21;
        9:       cm = 20;
        10:      cm = 13;
        11:      cm = 12;
        12:      cm = 9;
        13:      cm = 8;
        default: cm = $urandom_range(0, 60);
      endcase
      run_len = $urandom_range(1, 60);
      for (k = 0; k < run_len && sent < n_items; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(CMD_REMOTE, 16'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(0, 7) == 0) btn = !btn;
          mm = wild ? 16'($urandom) : 16'(cm * 10 + $urandom_range(0, 9));
          send_item(CMD_TICK, mm, btn);
        end
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    rst                  <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.command      <= CMD_TICK;
    item_ch.distance_mm  <= '0;
    item_ch.button_level <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_SERVICE_INTERVAL;
    cfg_ch.data          <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, register defaults
    send_item(CMD_REMOTE, 16'hFFFF, 1'b1);  // guard window not yet open: ignored
    send_item(CMD_TICK, 16'h0000, 1'b0);    // first tick services at once, solid band
    send_item(CMD_REMOTE, 16'h0000, 1'b0);  // accepted, to screen only
    send_item(CMD_REMOTE, 16'hFFFF, 1'b1);  // inside the guard window: ignored
    send_item(CMD_TICK, 16'hFFFF, 1'b1);    // between services, button not polled
    send_item(CMD_TICK, 16'h5555, 1'b0);
    send_item(CMD_TICK, 16'hAAAA, 1'b1);
    drain();

    // directed, service interval and guard programmed to zero
    program_regs(16'd0, 16'd0, 16'd1023, 16'd0);
    send_item(CMD_TICK, 16'd409, 1'b0);     // service counter still runs down from the old interval: outputs hold
    send_item(CMD_TICK, 16'd409, 1'b1);     // between services, button not polled
    send_item(CMD_TICK, 16'd410, 1'b1);     // between services, no beat starts
    send_item(CMD_REMOTE, 16'd0, 1'b0);     // guard count still runs from the old window: ignored
    send_item(CMD_REMOTE, 16'd0, 1'b0);     // window still shut: ignored
    send_item(CMD_TICK, 16'd0, 1'b0);       // between services, no change
    send_item(CMD_TICK, 16'd0, 1'b1);       // between services, button not polled, mode stays
    send_item(CMD_TICK, 16'd65535, 1'b0);
    drain();

    // extremes: fastest service and guard, widest beep range
    program_regs(16'd1, 16'd1, 16'd1023, 16'd0);
    run_phase(180);
    drain();

    // extremes: slowest service and guard, crossed limits so far test wins
    program_regs(16'd255, 16'd65535, 16'd0, 16'd1023);
    run_phase(150);
    drain();

    // zero service interval and zero guard with default limits
    program_regs(16'd0, 16'd0, 16'd55, 16'd4);
    run_phase(180);
    drain();

    // back to the defaults
    program_regs(16'(SVC_INTERVAL_RST), 16'(GUARD_MS_RST), 16'(FAR_LIMIT_RST),
                 16'(SOLID_LIMIT_RST));
    run_phase(180);
    drain();

    // random settings, unused upper data bits set at random
    for (p = 0; p < 4; p++) begin
      program_regs({8'($urandom), 8'($urandom_range(0, 5))}, 16'($urandom_range(0, 40)),
                   {6'($urandom), 10'($urandom_range(20, 80))},
                   {6'($urandom), 10'($urandom_range(0, 20))});
      run_phase(190);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pamc_pkg.sv
hw/rtl/pamc_in_if.sv
hw/rtl/pamc_out_if.sv
hw/rtl/pamc_cfg_if.sv
hw/rtl/pamc_in_stage.sv
hw/rtl/pamc_core.sv
hw/rtl/proximity_alarm_mode_controller_unit.sv
dv/pamc_checker.sv
dv/tb_top.sv
